/* rtl/tga_pixel_stream_decoder_defines.svh */
// assertion macros for the targa pixel stream decoder
// no dependencies; expects clk and arst_n in the including module
`ifndef TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TPSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define TPSD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define TPSD_ASSERT(lbl, prop, msg)

`define TPSD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/tpsd_pkg.sv */
// shared types and constants for the targa pixel stream decoder
// no dependencies
package tpsd_pkg;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		CFG_RLE_MODE     = 2'd0,
		CFG_PIXEL_DEPTH  = 2'd1,
		CFG_IMAGE_WIDTH  = 2'd2,
		CFG_IMAGE_HEIGHT = 2'd3
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	// pixel depth codes
	localparam logic [1:0] DEPTH_16 = 2'd0;
	localparam logic [1:0] DEPTH_24 = 2'd1;
	localparam logic [1:0] DEPTH_32 = 2'd2;
	// reserved depth code, no mode supports it
	localparam logic [1:0] DEPTH_BAD = 2'd3;

	localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
	localparam logic [7:0] RUN_BIAS     = 8'd127;

	// one decoded result beat
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       has_alpha;
		logic [7:0] repeat_res;
		logic       last;
		logic       error;
	} pix_res_t;

	// color fields of one pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       has_alpha;
	} pix_color_t;

endpackage

/* rtl/tga_pixel_stream_decoder.sv */
// a pixel beat is registered into the output buffer when its final byte is accepted
// throughput: one data byte per cycle; a two-entry output buffer keeps data_ready up
// while one result waits, so the input stalls only when both entries hold results
// reset (arst_n low): uncompressed mode, 24-bit depth, zero width and height, so
// no pixels are expected and bytes are dropped until width and height are written
// top level: targa pixel byte stream to decoded pixels; uses tpsd_pkg,
// tpsd_pixel_fmt, tpsd_out_skid and tga_pixel_stream_decoder_defines.svh
`include "tga_pixel_stream_decoder_defines.svh"

module tga_pixel_stream_decoder import tpsd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// byte stream
	input  logic                  data_valid,
	output logic                  data_ready,
	input  logic [7:0]            data_byte,
	// decoded pixels
	output logic                  pix_valid,
	input  logic                  pix_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [7:0]            alpha,
	output logic                  has_alpha,
	output logic [7:0]            repeat_res,
	output logic                  last,
	output logic                  error
);

	// configuration registers
	logic        rle_mode_q;
	logic [1:0]  pixel_depth_q;
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;

	// decode state
	logic [1:0]  byte_phase_q;
	logic [23:0] pixel_bytes_q;
	logic [7:0]  packet_left_q;
	logic        packet_is_run_q;
	logic [31:0] pixels_left_q;

	logic [1:0]  byte_phase_n;
	logic [23:0] pixel_bytes_n;
	logic [7:0]  packet_left_n;
	logic        packet_is_run_n;
	logic [31:0] pixels_left_n;

	// values after the current config write, used for the restart product
	logic [15:0] width_n;
	logic [15:0] height_n;
	logic [31:0] area;

	logic        accept;
	logic        depth_bad;
	logic        final_byte;
	logic [7:0]  run_rep;
	logic [7:0]  rep;
	logic [31:0] pixels_left_dec;
	logic        push;
	pix_res_t    res;
	pix_res_t    out_res;
	pix_color_t  color;
	logic        space;

	assign accept = data_valid && data_ready;

	// 16-bit pixels in run-length mode and the reserved depth code are rejected
	assign depth_bad = (pixel_depth_q == DEPTH_BAD) || (rle_mode_q && (pixel_depth_q == DEPTH_16));

	// final byte of a pixel when phase reaches depth code + 1 (2, 3 or 4 bytes)
	assign final_byte = ({1'b0, byte_phase_q} + 3'd1) == ({1'b0, pixel_depth_q} + 3'd2);

	// a run is clipped to the pixels still left in the image
	assign run_rep = (pixels_left_q < {24'b0, packet_left_q}) ? pixels_left_q[7:0]
	                                                          : packet_left_q;
	assign rep = (rle_mode_q && packet_is_run_q) ? run_rep : 8'd1;
	assign pixels_left_dec = pixels_left_q - {24'b0, rep};

	// restart count, one 16x16 product on a config write
	always_comb begin
		width_n  = image_width_q;
		height_n = image_height_q;
		if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_n  = cfg_wdata;
				CFG_IMAGE_HEIGHT: height_n = cfg_wdata;
				default: ;
			endcase
		end
	end

	assign area = width_n * height_n;

	tpsd_pixel_fmt u_fmt (
		.depth       (pixel_depth_q),
		.pixel_bytes (pixel_bytes_q),
		.final_byte  (data_byte),
		.color       (color)
	);

	// next-state and result for one accepted byte
	always_comb begin
		byte_phase_n    = byte_phase_q;
		pixel_bytes_n   = pixel_bytes_q;
		packet_left_n   = packet_left_q;
		packet_is_run_n = packet_is_run_q;
		pixels_left_n   = pixels_left_q;
		push            = 1'b0;
		res             = '0;
		if (accept) begin
			if (depth_bad) begin
				// error beat per byte, state untouched
				push      = 1'b1;
				res.error = 1'b1;
			end else if (pixels_left_q != 32'd0) begin
				if (rle_mode_q && (packet_left_q == 8'd0)) begin
					// packet header, no result
					if (data_byte < RUN_FLAG_MIN) begin
						packet_left_n   = data_byte + 8'd1;
						packet_is_run_n = 1'b0;
					end else begin
						packet_left_n   = data_byte - RUN_BIAS;
						packet_is_run_n = 1'b1;
					end
				end else if (!final_byte) begin
					// collect leading pixel bytes, little-endian
					pixel_bytes_n = pixel_bytes_q | ({16'b0, data_byte} << {byte_phase_q, 3'b000});
					byte_phase_n  = byte_phase_q + 2'd1;
				end else begin
					byte_phase_n  = 2'd0;
					pixel_bytes_n = 24'd0;
					if (rle_mode_q && packet_is_run_q) begin
						packet_left_n = 8'd0;
					end else if (rle_mode_q) begin
						packet_left_n = packet_left_q - 8'd1;
					end
					pixels_left_n = pixels_left_dec;
					if (pixels_left_dec == 32'd0) begin
						// image done, drop any rest of the packet
						packet_left_n = 8'd0;
					end
					push           = 1'b1;
					res.red        = color.red;
					res.green      = color.green;
					res.blue       = color.blue;
					res.alpha      = color.alpha;
					res.has_alpha  = color.has_alpha;
					res.repeat_res = rep;
					res.last       = (pixels_left_dec == 32'd0);
				end
			end
		end
	end

	// configuration and decode state; any config write restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q      <= 1'b0;
			pixel_depth_q   <= DEPTH_24;
			image_width_q   <= 16'd0;
			image_height_q  <= 16'd0;
			byte_phase_q    <= 2'd0;
			pixel_bytes_q   <= 24'd0;
			packet_left_q   <= 8'd0;
			packet_is_run_q <= 1'b0;
			pixels_left_q   <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RLE_MODE:     rle_mode_q    <= cfg_wdata[0];
				CFG_PIXEL_DEPTH:  pixel_depth_q <= cfg_wdata[1:0];
				default: ;
			endcase
			image_width_q   <= width_n;
			image_height_q  <= height_n;
			byte_phase_q    <= 2'd0;
			pixel_bytes_q   <= 24'd0;
			packet_left_q   <= 8'd0;
			packet_is_run_q <= 1'b0;
			pixels_left_q   <= area;
		end else begin
			byte_phase_q    <= byte_phase_n;
			pixel_bytes_q   <= pixel_bytes_n;
			packet_left_q   <= packet_left_n;
			packet_is_run_q <= packet_is_run_n;
			pixels_left_q   <= pixels_left_n;
		end
	end

	// result register with skid entry
	tpsd_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (res),
		.space     (space),
		.out_valid (pix_valid),
		.out_ready (pix_ready),
		.out_res   (out_res)
	);

	assign data_ready = space;

	assign red        = out_res.red;
	assign green      = out_res.green;
	assign blue       = out_res.blue;
	assign alpha      = out_res.alpha;
	assign has_alpha  = out_res.has_alpha;
	assign repeat_res = out_res.repeat_res;
	assign last       = out_res.last;
	assign error      = out_res.error;

	// a finished image never leaves a packet open
	`TPSD_ASSERT(a_done_no_packet, (pixels_left_q == 32'd0) |-> (packet_left_q == 8'd0), "packet open after image end")
	// the byte phase never passes the final byte of a pixel
	`TPSD_ASSERT_NEVER(a_phase_range, ({1'b0, byte_phase_q} > ({1'b0, pixel_depth_q} + 3'd1)), "byte phase out of range")
	// a full skid entry means the result register is occupied
	`TPSD_ASSERT(a_stall_has_beat, !data_ready |-> pix_valid, "input stalled with no pending beat")
	// a beat that is waiting keeps its run count
	`TPSD_ASSERT(a_hold_rep, (pix_valid && !pix_ready) |=> $stable(repeat_res), "stalled beat changed")

endmodule

/* rtl/tpsd_pixel_fmt.sv */
// pixel format conversion: 5-5-5 widening and bgr(a) to rgb(a) reorder
// depends on tpsd_pkg
module tpsd_pixel_fmt import tpsd_pkg::*; (
	input  logic [1:0]  depth,
	input  logic [23:0] pixel_bytes,
	input  logic [7:0]  final_byte,
	output pix_color_t  color
);

	logic [15:0] word16;

	assign word16 = {final_byte, pixel_bytes[7:0]};

	always_comb begin
		color = '0;
		unique case (depth)
			DEPTH_16: begin
				// bit 15 dropped
				color.blue  = {word16[4:0], 3'b000};
				color.green = {word16[9:5], 3'b000};
				color.red   = {word16[14:10], 3'b000};
			end
			DEPTH_24: begin
				color.blue  = pixel_bytes[7:0];
				color.green = pixel_bytes[15:8];
				color.red   = final_byte;
			end
			DEPTH_32: begin
				color.blue      = pixel_bytes[7:0];
				color.green     = pixel_bytes[15:8];
				color.red       = pixel_bytes[23:16];
				color.alpha     = final_byte;
				color.has_alpha = 1'b1;
			end
			default: begin
				color = '0;
			end
		endcase
	end

endmodule

/* rtl/tpsd_out_skid.sv */
// two-entry output buffer: result register plus skid register
// depends on tpsd_pkg
module tpsd_out_skid import tpsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pix_res_t push_res,
	output logic     space,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_res_t out_res
);

	logic     out_valid_q;
	logic     skid_valid_q;
	pix_res_t out_q;
	pix_res_t skid_q;
	logic     pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

endmodule
